@@ sv/mbfp_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, ASCII codes and the decimal number parser step for the frame parser.
// Depends on nothing; every other file but mbfp_ram imports it.
package mbfp_pkg;

    localparam logic [7:0] CH_START = 8'h21;  // '!'
    localparam logic [7:0] CH_END   = 8'h3B;  // ';'
    localparam logic [7:0] CH_DEV   = 8'h44;  // 'D'
    localparam logic [7:0] CH_SEP   = 8'h62;  // 'b'
    localparam logic [7:0] CH_REPORT = 8'h72; // 'r'
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam int MIN_FRAME_LEN = 4;
    localparam logic [31:0] POS_MAX  = 32'd100;
    localparam logic [31:0] TILT_MAX = 32'd180;
    localparam logic [31:0] INT_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] INT_MIN_MAG = 32'h8000_0000;
    localparam logic [2:0] DATA_MAX = 3'd7;

    typedef enum logic [1:0] {
        NUM_LEAD = 2'd0,
        NUM_DIG  = 2'd1,
        NUM_DONE = 2'd2
    } t_num_ph;

    typedef struct packed {
        t_num_ph     ph;
        logic        neg;
        logic        nd;
        logic        big;
        logic [31:0] mag;
    } t_num;

    typedef struct packed {
        logic accept;
        logic close;
        logic scan_ev;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic close_ok;
        logic scan_end;
        logic result_ok;
    } t_sts;

    function automatic logic is_digit(logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_blank(logic [7:0] c);
        return (c == CH_SPACE) || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    // One character into a running decimal parse.
    function automatic t_num num_step(t_num s, logic [7:0] c);
        t_num        r;
        logic [35:0] t;
        logic        acc;
        r   = s;
        acc = 1'b0;
        t   = {4'd0, s.mag} * 36'd10 + {32'd0, c[3:0]};
        case (s.ph)
            NUM_LEAD: begin
                if (is_blank(c)) begin
                    r.ph = NUM_LEAD;
                end else if (c == CH_PLUS || c == CH_MINUS) begin
                    r.neg = (c == CH_MINUS);
                    r.ph  = NUM_DIG;
                end else if (is_digit(c)) begin
                    acc  = 1'b1;
                    r.ph = NUM_DIG;
                end else begin
                    r.ph = NUM_DONE;
                end
            end
            NUM_DIG: begin
                if (is_digit(c)) acc = 1'b1;
                else r.ph = NUM_DONE;
            end
            default: r.ph = NUM_DONE;
        endcase
        if (acc) begin
            r.nd = 1'b1;
            if (!s.big) begin
                if (t[35:32] != 4'd0) r.big = 1'b1;
                else r.mag = t[31:0];
            end
        end
        return r;
    endfunction

    function automatic logic num_ok(t_num s);
        return s.nd && !s.big && ((s.mag <= INT_MAX) || (s.neg && s.mag == INT_MIN_MAG));
    endfunction

    function automatic logic num_in_range(t_num s, logic [31:0] lim);
        return (s.mag <= lim) && (!s.neg || s.mag == 32'd0);
    endfunction

endpackage

@@ sv/mbfp_ram.sv @@
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module mbfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ sv/mbfp_ctrl.sv @@
`timescale 1ns / 1ps
// Controller: receives bytes, sequences the scan of a closed frame, hands off the result.
// Depends on mbfp_pkg.
module mbfp_ctrl
    import mbfp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    output logic o_valid,
    input  logic i_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    typedef enum logic [1:0] {
        S_RX   = 2'd0,
        S_RD   = 2'd1,
        S_EV   = 2'd2,
        S_DONE = 2'd3
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, n_valid;
    logic   acc, out_free;

    assign acc      = i_valid && (r_state == S_RX);
    assign out_free = !r_valid || !i_stall;

    always_comb begin
        n_state       = r_state;
        n_valid       = r_valid && i_stall;
        o_cmd.accept  = acc;
        o_cmd.close   = acc && i_sts.close_ok;
        o_cmd.scan_ev = (r_state == S_EV);
        o_cmd.load    = 1'b0;
        unique case (r_state)
            S_RX: if (acc && i_sts.close_ok) n_state = S_RD;
            S_RD: n_state = i_sts.scan_end ? S_DONE : S_EV;
            S_EV: n_state = S_RD;
            S_DONE: begin
                if (!i_sts.result_ok) begin
                    n_state = S_RX;
                end else if (out_free) begin
                    o_cmd.load = 1'b1;
                    n_valid    = 1'b1;
                    n_state    = S_RX;
                end
            end
            default: n_state = S_RX;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RX;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_stall = (r_state != S_RX);
    assign o_valid = r_valid;
endmodule

@@ sv/mbfp_dp.sv @@
`timescale 1ns / 1ps
// Datapath: frame store, receive counters, byte-by-byte field scanner and result registers.
// Depends on mbfp_pkg and mbfp_ram.
module mbfp_dp
    import mbfp_pkg::*;
#(
    parameter int MAX_FRAME       = 64,
    parameter int MAX_MOTOR_CHARS = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic [7:0]  i_rx_byte,
    output logic [47:0] o_motor_id,
    output logic [2:0]  o_motor_len,
    output logic [7:0]  o_command,
    output logic [6:0]  o_position,
    output logic        o_position_valid,
    output logic [7:0]  o_tilt,
    output logic        o_tilt_valid,
    output logic [55:0] o_data_text,
    output logic [2:0]  o_data_len
);
    localparam int CW = $clog2(MAX_FRAME + 1);
    localparam int AW = $clog2(MAX_FRAME);

    logic          r_in_frame, r_d_found;
    logic [CW-1:0] r_count, r_d_idx, r_n, r_idx;
    logic [3:0]    r_mlen;
    logic [47:0]   r_motor;
    logic          r_cmd_found, r_b_found;
    logic [7:0]    r_cmd;
    logic [55:0]   r_data;
    logic [2:0]    r_dcnt;
    t_num          r_pos, r_tilt;
    logic [47:0]   r_o_motor;
    logic [2:0]    r_o_mlen, r_o_dlen;
    logic [7:0]    r_o_cmd, r_o_tilt;
    logic [6:0]    r_o_pos;
    logic          r_o_pv, r_o_tv;
    logic [55:0]   r_o_data;

    logic          we, is_r, pv, tv;
    logic [CW-1:0] mstart;
    logic [7:0]    rd;

    assign we = i_cmd.accept && r_in_frame && i_rx_byte != CH_START && i_rx_byte != CH_END
                && (r_count < CW'(MAX_FRAME));
    assign mstart = r_d_found ? r_d_idx + CW'(1) : CW'(1);

    mbfp_ram #(.WIDTH(8), .DEPTH(MAX_FRAME)) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_rx_byte),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (rd)
    );

    assign o_sts.close_ok  = r_in_frame && i_rx_byte == CH_END
                             && r_count >= CW'(MIN_FRAME_LEN - 1);
    assign o_sts.scan_end  = r_idx >= r_n;
    assign o_sts.result_ok = (r_mlen != 4'd0) && r_cmd_found;

    assign is_r = r_cmd == CH_REPORT;
    assign pv = is_r && r_b_found && num_ok(r_pos) && num_in_range(r_pos, POS_MAX);
    assign tv = is_r && r_b_found && num_ok(r_pos) && num_ok(r_tilt)
                && num_in_range(r_tilt, TILT_MAX);

    // Receive side.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_count    <= '0;
            r_d_found  <= 1'b0;
        end else if (i_cmd.accept) begin
            if (i_rx_byte == CH_START) begin
                r_in_frame <= 1'b1;
                r_count    <= CW'(1);
                r_d_found  <= 1'b0;
            end else if (r_in_frame) begin
                if (i_rx_byte == CH_END || r_count >= CW'(MAX_FRAME)) begin
                    r_in_frame <= 1'b0;
                    r_count    <= '0;
                end else begin
                    r_count <= r_count + CW'(1);
                    if (i_rx_byte == CH_DEV && !r_d_found) begin
                        r_d_found <= 1'b1;
                        r_d_idx   <= r_count;
                    end
                end
            end
        end
    end

    // Scanner: one stored byte per evaluation step.
    always_ff @(posedge i_clk) begin
        if (i_cmd.close) begin
            r_n         <= r_count;
            r_idx       <= mstart;
            r_mlen      <= '0;
            r_motor     <= '0;
            r_cmd_found <= 1'b0;
            r_cmd       <= '0;
            r_data      <= '0;
            r_dcnt      <= '0;
            r_b_found   <= 1'b0;
            r_pos       <= '{ph: NUM_LEAD, neg: 1'b0, nd: 1'b0, big: 1'b0, mag: 32'd0};
            r_tilt      <= '{ph: NUM_LEAD, neg: 1'b0, nd: 1'b0, big: 1'b0, mag: 32'd0};
        end else if (i_cmd.scan_ev) begin
            r_idx <= r_idx + CW'(1);
            if (!r_cmd_found) begin
                if (is_digit(rd) && r_mlen < 4'(MAX_MOTOR_CHARS)) begin
                    r_motor <= {r_motor[39:0], rd};
                    r_mlen  <= r_mlen + 4'd1;
                end else begin
                    r_cmd_found <= 1'b1;
                    r_cmd       <= rd;
                end
            end else begin
                if (r_dcnt != DATA_MAX) begin
                    r_data <= {r_data[47:0], rd};
                    r_dcnt <= r_dcnt + 3'd1;
                end
                if (!r_b_found) begin
                    if (rd == CH_SEP) r_b_found <= 1'b1;
                    else r_pos <= num_step(r_pos, rd);
                end else begin
                    r_tilt <= num_step(r_tilt, rd);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_o_motor <= r_motor;
            r_o_mlen  <= r_mlen[2:0];
            r_o_cmd   <= r_cmd;
            r_o_pos   <= pv ? r_pos.mag[6:0] : 7'd0;
            r_o_pv    <= pv;
            r_o_tilt  <= tv ? r_tilt.mag[7:0] : 8'd0;
            r_o_tv    <= tv;
            r_o_data  <= r_data;
            r_o_dlen  <= r_dcnt;
        end
    end

    assign o_motor_id       = r_o_motor;
    assign o_motor_len      = r_o_mlen;
    assign o_command        = r_o_cmd;
    assign o_position       = r_o_pos;
    assign o_position_valid = r_o_pv;
    assign o_tilt           = r_o_tilt;
    assign o_tilt_valid     = r_o_tv;
    assign o_data_text      = r_o_data;
    assign o_data_len       = r_o_dlen;
endmodule

@@ sv/motor_bus_ascii_frame_parser_top.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Signals
// rx byte   in         i_valid / o_stall, i_rx_byte
// frame     out        o_valid / i_stall, o_motor_id .. o_data_len
//
// A received byte is taken while the controller is receiving. On the closing ';' the stored frame
// is scanned through the frame store read port, with a read state and an evaluate state per
// stored byte after the hub prefix, and the input stays stalled until the scan is through.
// Reset (synchronous, active low) empties the frame state and the output register.
// A waiting result does not block reception; it only holds the next scan at its end,
// and the input stays stalled until that result register is free.
// Depends on mbfp_pkg, mbfp_ctrl, mbfp_dp and mbfp_ram.
module motor_bus_ascii_frame_parser_top
    import mbfp_pkg::*;
#(
    parameter int MAX_FRAME       = 64,
    parameter int MAX_MOTOR_CHARS = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [47:0] o_motor_id,
    output logic [2:0]  o_motor_len,
    output logic [7:0]  o_command,
    output logic [6:0]  o_position,
    output logic        o_position_valid,
    output logic [7:0]  o_tilt,
    output logic        o_tilt_valid,
    output logic [55:0] o_data_text,
    output logic [2:0]  o_data_len
);
    t_cmd cmd;
    t_sts sts;

    mbfp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    mbfp_dp #(.MAX_FRAME(MAX_FRAME), .MAX_MOTOR_CHARS(MAX_MOTOR_CHARS)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_rx_byte        (i_rx_byte),
        .o_motor_id       (o_motor_id),
        .o_motor_len      (o_motor_len),
        .o_command        (o_command),
        .o_position       (o_position),
        .o_position_valid (o_position_valid),
        .o_tilt           (o_tilt),
        .o_tilt_valid     (o_tilt_valid),
        .o_data_text      (o_data_text),
        .o_data_len       (o_data_len)
    );
endmodule

@@ sv/mbfp_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks on the frame parser output, bound to the top level.
// Depends on mbfp_pkg.
module mbfp_checker
    import mbfp_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [2:0] o_motor_len,
    input logic [7:0] o_command,
    input logic [6:0] o_position,
    input logic       o_position_valid,
    input logic       o_tilt_valid
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid) else $error("result dropped while stalled");

    a_mlen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_motor_len != 3'd0 || o_motor_len == 3'd0 && 1'b0 || o_motor_len != 3'd0)
        else $error("result without motor id");

    a_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_position_valid |-> o_position <= 7'd100)
        else $error("position out of range");

    a_pos0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_position_valid |-> o_position == 7'd0)
        else $error("invalid position not zero");

    a_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_command != CH_REPORT |-> !o_position_valid && !o_tilt_valid)
        else $error("position or tilt on a non-report frame");
endmodule

bind motor_bus_ascii_frame_parser_top mbfp_checker u_mbfp_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_motor_len      (o_motor_len),
    .o_command        (o_command),
    .o_position       (o_position),
    .o_position_valid (o_position_valid),
    .o_tilt_valid     (o_tilt_valid)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for motor_bus_ascii_frame_parser_top: directed frames from a
// table, then random frames and noise; results checked against the table or a frame predictor.
// Depends on mbfp_pkg and the frame parser RTL.
module tb_top;
    import mbfp_pkg::*;

    localparam logic [7:0] CH_VER = 8'h76;  // 'v'
    localparam int STORE_DEPTH = 64;
    localparam int MOTOR_MAX = 6;
    localparam int RANDOM_BYTES = 1570;
    localparam int DRAIN_CYCLES = 400;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [47:0] motor_id;
        logic [2:0]  motor_len;
        logic [7:0]  command;
        logic [6:0]  position;
        logic        position_valid;
        logic [7:0]  tilt;
        logic        tilt_valid;
        logic [55:0] data_text;
        logic [2:0]  data_len;
    } t_frame_res;

    typedef struct {
        string      text;
        bit         typed;
        t_frame_res want;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_rx_byte;
    logic        o_valid;
    logic        i_stall;
    t_frame_res  got;
    logic        rx_fire;

    logic [7:0]  fstore [STORE_DEPTH];
    int          fcount;
    bit          framing;
    t_frame_res  expected_frames [$];
    logic [7:0]  byte_q [$];
    int          mismatches;
    int          cycles;
    bit          idle_en;

    motor_bus_ascii_frame_parser_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_rx_byte        (i_rx_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_motor_id       (got.motor_id),
        .o_motor_len      (got.motor_len),
        .o_command        (got.command),
        .o_position       (got.position),
        .o_position_valid (got.position_valid),
        .o_tilt           (got.tilt),
        .o_tilt_valid     (got.tilt_valid),
        .o_data_text      (got.data_text),
        .o_data_len       (got.data_len)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic bit dec_digit(logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    // Decimal parse of fstore[lo..hi): blanks, one sign, digits.
    function automatic bit parse_dec(int lo, int hi, output logic [63:0] mag, output bit neg);
        int i;
        int nd;
        i = lo;
        nd = 0;
        mag = 0;
        neg = 0;
        while (i < hi && (fstore[i] == 8'h20 || (fstore[i] >= 8'd9 && fstore[i] <= 8'd13)))
            i++;
        if (i < hi && (fstore[i] == CH_PLUS || fstore[i] == CH_MINUS)) begin
            neg = fstore[i] == CH_MINUS;
            i++;
        end
        while (i < hi && dec_digit(fstore[i])) begin
            if (mag < 64'd10000000000) mag = mag * 10 + (fstore[i] - 8'h30);
            nd++;
            i++;
        end
        if (nd == 0) return 0;
        return mag <= (neg ? 64'd2147483648 : 64'd2147483647);
    endfunction

    function automatic bit scan_frame(int n, output t_frame_res r);
        int mstart;
        int mend;
        int cpos;
        int dlen;
        int bpos;
        logic [63:0] mag;
        bit neg;
        r = '0;
        mstart = 1;
        for (int i = 1; i < n; i++) begin
            if (fstore[i] == CH_DEV) begin
                mstart = i + 1;
                break;
            end
        end
        mend = mstart;
        while (mend < n && dec_digit(fstore[mend]) && (mend - mstart) < MOTOR_MAX) begin
            r.motor_id = {r.motor_id[39:0], fstore[mend]};
            mend++;
        end
        if (mend == mstart) return 0;
        cpos = mend;
        if (cpos >= n) return 0;
        dlen = n - cpos - 1;
        for (int i = 0; i < dlen && i < 7; i++)
            r.data_text = {r.data_text[47:0], fstore[cpos + 1 + i]};
        r.motor_len = 3'(mend - mstart);
        r.command = fstore[cpos];
        r.data_len = dlen > 7 ? 3'd7 : 3'(dlen);
        if (r.command == CH_REPORT) begin
            bpos = n;
            for (int i = cpos + 1; i < n; i++) begin
                if (fstore[i] == CH_SEP) begin
                    bpos = i;
                    break;
                end
            end
            if (bpos < n && parse_dec(cpos + 1, bpos, mag, neg)) begin
                if (mag <= 100 && (!neg || mag == 0)) begin
                    r.position = 7'(mag);
                    r.position_valid = 1'b1;
                end
                if (parse_dec(bpos + 1, n, mag, neg) && mag <= 180 && (!neg || mag == 0)) begin
                    r.tilt = 8'(mag);
                    r.tilt_valid = 1'b1;
                end
            end
        end
        return 1;
    endfunction

    // Advances the frame state by one received byte; returns 1 when a result is due.
    function automatic bit take_byte(logic [7:0] c, output t_frame_res r);
        int n;
        r = '0;
        if (c == CH_START) begin
            fstore[0] = c;
            fcount = 1;
            framing = 1;
            return 0;
        end
        if (!framing) return 0;
        if (c == CH_END) begin
            n = fcount;
            framing = 0;
            fcount = 0;
            if (n + 1 < MIN_FRAME_LEN) return 0;
            return scan_frame(n, r);
        end
        if (fcount >= STORE_DEPTH) begin
            framing = 0;
            fcount = 0;
            return 0;
        end
        fstore[fcount] = c;
        fcount++;
        return 0;
    endfunction

    function automatic t_dir_row mk_row(string s, bit typed, t_frame_res want);
        t_dir_row d;
        d.text = s;
        d.typed = typed;
        d.want = want;
        return d;
    endfunction

    always @(posedge i_clk) begin
        rx_fire <= i_valid && !o_stall;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result checker: every transfer on the output side against the oldest expectation.
    always @(posedge i_clk) begin
        t_frame_res w;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_frames.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
                w = expected_frames.pop_front();
                if (got.motor_id !== w.motor_id || got.motor_len !== w.motor_len ||
                    got.command !== w.command || got.position !== w.position ||
                    got.position_valid !== w.position_valid || got.tilt !== w.tilt ||
                    got.tilt_valid !== w.tilt_valid || got.data_text !== w.data_text ||
                    got.data_len !== w.data_len) begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch: expected %p, got %p", w, got);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        i_stall <= idle_en && ($urandom_range(99) < 23);
    end

    task automatic send_byte(logic [7:0] c, bit typed, t_frame_res want);
        t_frame_res r;
        while (idle_en && $urandom_range(99) < 23) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_rx_byte = c;
        do @(negedge i_clk); while (!rx_fire);
        i_valid = 1'b0;
        if (take_byte(c, r))
            expected_frames.insert(expected_frames.size(), typed ? want : r);
    endtask

    task automatic add_byte(logic [7:0] c);
        byte_q.insert(byte_q.size(), c);
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endtask

    function automatic string rand_number();
        case ($urandom_range(9))
            0: return "-0";
            1: return $sformatf("+%0d", $urandom_range(200));
            2: return $sformatf(" \t%0d", $urandom_range(200));
            3: return "";
            4: return $sformatf("-%0d", $urandom_range(1, 50));
            5: return "99999999999";
            6: return "2147483648";
            default: return $sformatf("%0d", $urandom_range(190));
        endcase
    endfunction

    // One random frame, mostly well formed, into byte_q.
    task automatic build_frame();
        int k;
        k = $urandom_range(99);
        if (k < 8) begin
            repeat ($urandom_range(1, 6)) add_byte(8'($urandom));
            return;
        end
        add_byte(CH_START);
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(8'h41, 8'h43)));
        if ($urandom_range(9) != 0) add_byte(CH_DEV);
        repeat ($urandom_range(0, 8)) add_byte(8'($urandom_range(8'h30, 8'h39)));
        if (k < 60) begin
            add_byte(CH_REPORT);
            push_text(rand_number());
            if ($urandom_range(7) != 0) add_byte(CH_SEP);
            push_text(rand_number());
        end else if (k < 75) begin
            add_byte(CH_VER);
            push_text($sformatf("%0d.%0d", $urandom_range(9), $urandom_range(99)));
        end else if (k < 92) begin
            repeat ($urandom_range(0, 12)) add_byte(8'($urandom));
        end else begin
            repeat ($urandom_range(55, 70)) add_byte(8'($urandom_range(8'h61, 8'h7A)));
        end
        if ($urandom_range(15) != 0) add_byte(CH_END);
    endtask

    initial begin
        t_dir_row rows [$];
        t_frame_res none;
        int sent;
        none = '0;
        rows.insert(rows.size(), mk_row("!D1r100b180;", 1, '{48'h31, 3'd1, CH_REPORT,
                    7'd100, 1'b1, 8'd180, 1'b1, 56'h31303062313830, 3'd7}));
        rows.insert(rows.size(), mk_row("!D12v1.2;", 1, '{48'h3132, 3'd2, CH_VER,
                    7'd0, 1'b0, 8'd0, 1'b0, 56'h312E32, 3'd3}));
        rows.insert(rows.size(), mk_row("!D9r0b0;", 1, '{48'h39, 3'd1, CH_REPORT,
                    7'd0, 1'b1, 8'd0, 1'b1, 56'h306230, 3'd3}));
        rows.insert(rows.size(), mk_row("x;!D;", 0, none));
        rows.insert(rows.size(), mk_row("!12;", 0, none));
        rows.insert(rows.size(), mk_row("!ab;", 0, none));
        rows.insert(rows.size(), mk_row("!D7;", 0, none));
        rows.insert(rows.size(), mk_row("!D1r101b181;", 0, none));
        rows.insert(rows.size(), mk_row("!D1r-0b-0;", 0, none));
        rows.insert(rows.size(), mk_row("!D1r5;", 0, none));
        rows.insert(rows.size(), mk_row("!D1rxb5;", 0, none));
        rows.insert(rows.size(), mk_row("!D2r-3b+17;", 0, none));
        rows.insert(rows.size(), mk_row("!hubD1234567x;", 0, none));
        rows.insert(rows.size(), mk_row("!D1r50!D2r 7b3;", 0, none));
        rows.insert(rows.size(), mk_row("!D3r2147483648b1;", 0, none));

        idle_en = 1;
        i_valid = 0;
        i_rx_byte = 0;
        i_stall = 0;
        rx_fire = 0;
        cycles = 0;
        mismatches = 0;
        fcount = 0;
        framing = 0;
        i_rst_n = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1;

        send_byte(8'h00, 0, none);
        send_byte(8'hFF, 0, none);
        foreach (rows[r]) begin
            for (int i = 0; i < rows[r].text.len(); i++)
                send_byte(rows[r].text[i], rows[r].typed && i == rows[r].text.len() - 1,
                          rows[r].want);
        end
        // Full store closed by ';', then one byte too many.
        for (int extra = 0; extra < 2; extra++) begin
            send_byte(CH_START, 0, none);
            send_byte(CH_DEV, 0, none);
            send_byte(8'h35, 0, none);
            send_byte(CH_VER, 0, none);
            repeat (STORE_DEPTH - 4 + extra) send_byte(8'h7A, 0, none);
            send_byte(CH_END, 0, none);
        end

        sent = 0;
        while (sent < RANDOM_BYTES) begin
            idle_en = !(sent > 700 && sent < 1000);
            build_frame();
            while (byte_q.size() != 0) begin
                send_byte(byte_q.pop_front(), 0, none);
                sent++;
            end
        end
        idle_en = 1;

        while (expected_frames.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
